FILE: design/mrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU slave package
// Shared constants, codes, state and operation types and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // Default sizes of the block.
  localparam int REG_DEPTH_DEF     = 256;
  localparam int FRAME_BYTES_DEF   = 64;
  localparam int MAX_READ_REGS_DEF = 16;
  localparam int MAX_COILS_DEF     = 256;

  // Longest reply frame in bytes, CRC included.
  localparam int MAX_OUT = 37;

  // Width used for address and count arithmetic.
  localparam int AW_WIDE = 18;

  // Input opcodes.
  localparam logic [1:0] OPC_RX_BYTE   = 2'd0;
  localparam logic [1:0] OPC_END_FRAME = 2'd1;
  localparam logic [1:0] OPC_LOCAL_RD  = 2'd2;
  localparam logic [1:0] OPC_LOCAL_WR  = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WDONE = 2'd2;
  localparam logic [1:0] KIND_DROP  = 2'd3;

  // Drop causes.
  localparam logic [1:0] CAUSE_CRC  = 2'd0;
  localparam logic [1:0] CAUSE_ADDR = 2'd1;
  localparam logic [1:0] CAUSE_FUNC = 2'd2;
  localparam logic [1:0] CAUSE_LEN  = 2'd3;

  // Modbus function codes.
  localparam logic [7:0] FN_READ_COILS  = 8'h01;
  localparam logic [7:0] FN_READ_REGS   = 8'h03;
  localparam logic [7:0] FN_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FN_WRITE_REGS  = 8'h10;

  // Configuration register indexes.
  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_COIL_BASE  = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LRD,
    ST_SCAN,
    ST_CHECK,
    ST_HDR,
    ST_RREG,
    ST_RCOIL,
    ST_WREG,
    ST_WCOIL,
    ST_CRC
  } mrs_state_t;

  typedef enum logic [1:0] {
    OP_RREG,
    OP_RCOIL,
    OP_WREG,
    OP_WCOIL
  } mrs_op_t;

  // One byte of the reflected CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int j = 0; j < 8; j++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

FILE: design/mrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/mrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU slave sequencer
// Collects frame bytes, checks and serves frames over the register store.
// ----------------------------------------------------------------------------
module mrs_ctrl #(
  parameter int REG_DEPTH     = mrs_pkg::REG_DEPTH_DEF,
  parameter int FRAME_BYTES   = mrs_pkg::FRAME_BYTES_DEF,
  parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEF,
  parameter int MAX_COILS     = mrs_pkg::MAX_COILS_DEF,
  localparam int AW  = $clog2(REG_DEPTH),
  localparam int FAW = $clog2(FRAME_BYTES),
  localparam int FLW = $clog2(FRAME_BYTES + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     opcode,
  input  logic [7:0]     rx_byte,
  input  logic [7:0]     local_index,
  input  logic [15:0]    local_data,
  input  logic [7:0]     slave_addr,
  input  logic [7:0]     coil_base,
  // Register store port
  output logic           st_we,
  output logic [AW-1:0]  st_waddr,
  output logic [15:0]    st_wdata,
  output logic [AW-1:0]  st_raddr,
  input  logic [15:0]    st_rdata,
  // Frame buffer port
  output logic           fb_we,
  output logic [FAW-1:0] fb_waddr,
  output logic [7:0]     fb_wdata,
  output logic [FAW-1:0] fb_raddr,
  input  logic [7:0]     fb_rdata,
  // Result word
  output logic           out_strobe,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_tx_byte,
  output logic [15:0]    out_read_word,
  output logic [1:0]     out_drop_cause,
  output logic           out_last
);

  localparam logic [mrs_pkg::AW_WIDE-1:0] DEPTH_W = mrs_pkg::AW_WIDE'(REG_DEPTH);
  localparam logic [16:0] MAXR_W = 17'(MAX_READ_REGS);
  localparam logic [16:0] MAXC_W = 17'(MAX_COILS);
  localparam logic [16:0] MAXO_W = 17'(mrs_pkg::MAX_OUT);

  mrs_pkg::mrs_state_t state_r, state_nxt;
  mrs_pkg::mrs_op_t    op_r, op_nxt;

  logic [AW-1:0]  clr_r, clr_nxt;
  logic [FLW-1:0] flen_cur_r, flen_cur_nxt;
  logic           ovf_r, ovf_nxt;
  logic [FLW-1:0] flen_r, flen_nxt;
  logic [FLW-1:0] sidx_r, sidx_nxt;
  logic [FLW-1:0] didx_r, didx_nxt;
  logic           dval_r, dval_nxt;
  logic [7:0]     hdr_r [7];
  logic [7:0]     hdr_nxt [7];
  logic [15:0]    crc_calc_r, crc_calc_nxt;
  logic [7:0]     fcrc_lo_r, fcrc_lo_nxt;
  logic [7:0]     fcrc_hi_r, fcrc_hi_nxt;
  logic [15:0]    crc_out_r, crc_out_nxt;
  logic           rng_r, rng_nxt;
  logic           lrng_r, lrng_nxt;
  logic [7:0]     rnb_r, rnb_nxt;
  logic [15:0]    k_r, k_nxt;
  logic [1:0]     ph_r, ph_nxt;
  logic [2:0]     hcnt_r, hcnt_nxt;
  logic [7:0]     acc_r, acc_nxt;
  logic [15:0]    word_r, word_nxt;
  logic [3:0]     bitsel_r, bitsel_nxt;
  logic [AW-1:0]  waddr_r, waddr_nxt;

  logic           strobe_r, strobe_nxt;
  logic [1:0]     kind_r, kind_nxt;
  logic [7:0]     tx_r, tx_nxt;
  logic [15:0]    rword_r, rword_nxt;
  logic [1:0]     cause_r, cause_nxt;
  logic           last_r, last_nxt;

  // Decoded request fields and range arithmetic.
  logic [7:0]  fn;
  logic [15:0] req_start, req_cnt;
  logic [16:0] cnt17, two_cnt, coil_nb, reg_end, coil_last, pos17;
  logic [mrs_pkg::AW_WIDE-1:0] coil_top, coil_word, idx_w;
  logic [9:0]  body, wr_len;
  logic        reg_rng, coil_rng, crc_ok, k_last;
  logic [16:0] buf_a0, buf_a1, buf_ac;

  assign fn        = hdr_r[1];
  assign req_start = {hdr_r[2], hdr_r[3]};
  assign req_cnt   = {hdr_r[4], hdr_r[5]};
  assign cnt17     = {1'b0, req_cnt};
  assign two_cnt   = {req_cnt, 1'b0};
  assign coil_nb   = (cnt17 + 17'd7) >> 3;
  assign reg_end   = {1'b0, req_start} + cnt17;
  assign coil_last = (reg_end - 17'd1) >> 4;
  assign coil_top  = mrs_pkg::AW_WIDE'(coil_base) + mrs_pkg::AW_WIDE'(coil_last);
  assign reg_rng   = mrs_pkg::AW_WIDE'(reg_end) <= DEPTH_W;
  assign coil_rng  = coil_top < DEPTH_W;
  assign body      = 10'(flen_r) - 10'd2;
  assign wr_len    = {2'b00, hdr_r[6]} + 10'd7;
  assign crc_ok    = crc_calc_r == {fcrc_hi_r, fcrc_lo_r};
  assign k_last    = (k_r + 16'd1) == req_cnt;
  assign pos17     = {1'b0, req_start} + {1'b0, k_r};
  assign coil_word = mrs_pkg::AW_WIDE'(coil_base) + mrs_pkg::AW_WIDE'(pos17 >> 4);
  assign idx_w     = mrs_pkg::AW_WIDE'(local_index);
  assign buf_a0    = 17'd7 + {k_r, 1'b0};
  assign buf_a1    = 17'd8 + {k_r, 1'b0};
  assign buf_ac    = 17'd7 + {4'd0, k_r[15:3]};

  assign busy = state_r != mrs_pkg::ST_IDLE;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mrs_pkg::ST_CLEAR;
      clr_r      <= '0;
      flen_cur_r <= '0;
      ovf_r      <= 1'b0;
      strobe_r   <= 1'b0;
      dval_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      flen_cur_r <= flen_cur_nxt;
      ovf_r      <= ovf_nxt;
      strobe_r   <= strobe_nxt;
      dval_r     <= dval_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    flen_r     <= flen_nxt;
    sidx_r     <= sidx_nxt;
    didx_r     <= didx_nxt;
    hdr_r      <= hdr_nxt;
    crc_calc_r <= crc_calc_nxt;
    fcrc_lo_r  <= fcrc_lo_nxt;
    fcrc_hi_r  <= fcrc_hi_nxt;
    crc_out_r  <= crc_out_nxt;
    rng_r      <= rng_nxt;
    lrng_r     <= lrng_nxt;
    rnb_r      <= rnb_nxt;
    k_r        <= k_nxt;
    ph_r       <= ph_nxt;
    hcnt_r     <= hcnt_nxt;
    acc_r      <= acc_nxt;
    word_r     <= word_nxt;
    bitsel_r   <= bitsel_nxt;
    waddr_r    <= waddr_nxt;
    kind_r     <= kind_nxt;
    tx_r       <= tx_nxt;
    rword_r    <= rword_nxt;
    cause_r    <= cause_nxt;
    last_r     <= last_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_kind       = kind_r;
  assign out_tx_byte    = tx_r;
  assign out_read_word  = rword_r;
  assign out_drop_cause = cause_r;
  assign out_last       = last_r;

  // Next state, memory accesses and results.
  always_comb begin
    logic [7:0]  hb;
    logic [15:0] w;
    logic        bit_v;
    logic [7:0]  accn;
    logic        hdr_done;

    state_nxt    = state_r;
    op_nxt       = op_r;
    clr_nxt      = clr_r;
    flen_cur_nxt = flen_cur_r;
    ovf_nxt      = ovf_r;
    flen_nxt     = flen_r;
    sidx_nxt     = sidx_r;
    didx_nxt     = didx_r;
    dval_nxt     = 1'b0;
    hdr_nxt      = hdr_r;
    crc_calc_nxt = crc_calc_r;
    fcrc_lo_nxt  = fcrc_lo_r;
    fcrc_hi_nxt  = fcrc_hi_r;
    crc_out_nxt  = crc_out_r;
    rng_nxt      = rng_r;
    lrng_nxt     = lrng_r;
    rnb_nxt      = rnb_r;
    k_nxt        = k_r;
    ph_nxt       = ph_r;
    hcnt_nxt     = hcnt_r;
    acc_nxt      = acc_r;
    word_nxt     = word_r;
    bitsel_nxt   = bitsel_r;
    waddr_nxt    = waddr_r;

    strobe_nxt = 1'b0;
    kind_nxt   = mrs_pkg::KIND_BYTE;
    tx_nxt     = 8'h00;
    rword_nxt  = 16'h0000;
    cause_nxt  = mrs_pkg::CAUSE_CRC;
    last_nxt   = 1'b0;

    st_we    = 1'b0;
    st_waddr = clr_r;
    st_wdata = 16'h0000;
    st_raddr = idx_w[AW-1:0];
    fb_we    = 1'b0;
    fb_waddr = flen_cur_r[FAW-1:0];
    fb_wdata = rx_byte;
    fb_raddr = sidx_r[FAW-1:0];

    hb       = 8'h00;
    w        = 16'h0000;
    bit_v    = 1'b0;
    accn     = 8'h00;
    hdr_done = 1'b0;

    case (state_r)
      // Zero the register store after reset.
      mrs_pkg::ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == AW'(REG_DEPTH - 1)) begin
          state_nxt = mrs_pkg::ST_IDLE;
        end
      end

      // Take one input word.
      mrs_pkg::ST_IDLE: begin
        if (start) begin
          case (opcode)
            mrs_pkg::OPC_RX_BYTE: begin
              if (flen_cur_r < FLW'(FRAME_BYTES)) begin
                fb_we        = 1'b1;
                flen_cur_nxt = flen_cur_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            mrs_pkg::OPC_END_FRAME: begin
              flen_nxt     = flen_cur_r;
              flen_cur_nxt = '0;
              ovf_nxt      = 1'b0;
              sidx_nxt     = '0;
              crc_calc_nxt = mrs_pkg::CRC_INIT;
              if (ovf_r) begin
                strobe_nxt = 1'b1;
                kind_nxt   = mrs_pkg::KIND_DROP;
                cause_nxt  = mrs_pkg::CAUSE_LEN;
                last_nxt   = 1'b1;
              end else if (flen_cur_r < FLW'(4)) begin
                strobe_nxt = 1'b1;
                kind_nxt   = mrs_pkg::KIND_DROP;
                cause_nxt  = mrs_pkg::CAUSE_CRC;
                last_nxt   = 1'b1;
              end else begin
                state_nxt = mrs_pkg::ST_SCAN;
              end
            end
            mrs_pkg::OPC_LOCAL_RD: begin
              st_raddr  = idx_w[AW-1:0];
              lrng_nxt  = idx_w < DEPTH_W;
              state_nxt = mrs_pkg::ST_LRD;
            end
            mrs_pkg::OPC_LOCAL_WR: begin
              st_we      = idx_w < DEPTH_W;
              st_waddr   = idx_w[AW-1:0];
              st_wdata   = local_data;
              strobe_nxt = 1'b1;
              kind_nxt   = mrs_pkg::KIND_WDONE;
              last_nxt   = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      // Local read data is back from the store.
      mrs_pkg::ST_LRD: begin
        strobe_nxt = 1'b1;
        kind_nxt   = mrs_pkg::KIND_READ;
        rword_nxt  = lrng_r ? st_rdata : 16'h0000;
        last_nxt   = 1'b1;
        state_nxt  = mrs_pkg::ST_IDLE;
      end

      // Stream the frame through the CRC and capture the header and the frame CRC.
      mrs_pkg::ST_SCAN: begin
        fb_raddr = sidx_r[FAW-1:0];
        if (sidx_r < flen_r) begin
          sidx_nxt = sidx_r + 1'b1;
          didx_nxt = sidx_r;
          dval_nxt = 1'b1;
        end
        if (dval_r) begin
          if (didx_r < flen_r - FLW'(2)) begin
            crc_calc_nxt = mrs_pkg::crc_byte(crc_calc_r, fb_rdata);
          end
          if (didx_r == flen_r - FLW'(2)) begin
            fcrc_lo_nxt = fb_rdata;
          end
          if (didx_r == flen_r - FLW'(1)) begin
            fcrc_hi_nxt = fb_rdata;
            state_nxt   = mrs_pkg::ST_CHECK;
          end
          for (int j = 0; j < 7; j++) begin
            if (didx_r == FLW'(j)) begin
              hdr_nxt[j] = fb_rdata;
            end
          end
        end
      end

      // Validate the request and pick the service.
      mrs_pkg::ST_CHECK: begin
        strobe_nxt  = 1'b1;
        kind_nxt    = mrs_pkg::KIND_DROP;
        cause_nxt   = mrs_pkg::CAUSE_LEN;
        last_nxt    = 1'b1;
        state_nxt   = mrs_pkg::ST_IDLE;
        k_nxt       = 16'd0;
        ph_nxt      = 2'd0;
        hcnt_nxt    = 3'd0;
        acc_nxt     = 8'h00;
        crc_out_nxt = mrs_pkg::CRC_INIT;
        if (!crc_ok) begin
          cause_nxt = mrs_pkg::CAUSE_CRC;
        end else if (hdr_r[0] != slave_addr) begin
          cause_nxt = mrs_pkg::CAUSE_ADDR;
        end else if (!(fn inside {mrs_pkg::FN_READ_REGS, mrs_pkg::FN_WRITE_REGS,
                                  mrs_pkg::FN_READ_COILS, mrs_pkg::FN_WRITE_COILS})) begin
          cause_nxt = mrs_pkg::CAUSE_FUNC;
        end else if (body < 10'd6) begin
          cause_nxt = mrs_pkg::CAUSE_LEN;
        end else if (fn == mrs_pkg::FN_READ_REGS) begin
          if (body == 10'd6 && cnt17 != 17'd0 && cnt17 <= MAXR_W &&
              two_cnt + 17'd5 <= MAXO_W) begin
            strobe_nxt = 1'b0;
            op_nxt     = mrs_pkg::OP_RREG;
            rng_nxt    = reg_rng;
            rnb_nxt    = two_cnt[7:0];
            state_nxt  = mrs_pkg::ST_HDR;
          end
        end else if (fn == mrs_pkg::FN_READ_COILS) begin
          if (body == 10'd6 && cnt17 != 17'd0 && cnt17 <= MAXC_W &&
              coil_nb + 17'd5 <= MAXO_W) begin
            strobe_nxt = 1'b0;
            op_nxt     = mrs_pkg::OP_RCOIL;
            rng_nxt    = coil_rng;
            rnb_nxt    = coil_nb[7:0];
            state_nxt  = mrs_pkg::ST_HDR;
          end
        end else if (body < 10'd7) begin
          cause_nxt = mrs_pkg::CAUSE_LEN;
        end else if (fn == mrs_pkg::FN_WRITE_REGS) begin
          if (cnt17 != 17'd0 && cnt17 <= MAXR_W && {9'd0, hdr_r[6]} == two_cnt &&
              body == wr_len) begin
            strobe_nxt = 1'b0;
            op_nxt     = mrs_pkg::OP_WREG;
            state_nxt  = reg_rng ? mrs_pkg::ST_WREG : mrs_pkg::ST_HDR;
          end
        end else begin
          if (cnt17 != 17'd0 && cnt17 <= MAXC_W && {9'd0, hdr_r[6]} == coil_nb &&
              body == wr_len) begin
            strobe_nxt = 1'b0;
            op_nxt     = mrs_pkg::OP_WCOIL;
            state_nxt  = coil_rng ? mrs_pkg::ST_WCOIL : mrs_pkg::ST_HDR;
          end
        end
      end

      // Reply header: address, function, then byte count or echo fields.
      mrs_pkg::ST_HDR: begin
        case (hcnt_r)
          3'd0: hb = hdr_r[0];
          3'd1: hb = hdr_r[1];
          3'd2: hb = (op_r == mrs_pkg::OP_RREG || op_r == mrs_pkg::OP_RCOIL) ?
                     rnb_r : hdr_r[2];
          3'd3: hb = hdr_r[3];
          3'd4: hb = hdr_r[4];
          3'd5: hb = hdr_r[5];
          default: hb = 8'h00;
        endcase
        strobe_nxt  = 1'b1;
        tx_nxt      = hb;
        crc_out_nxt = mrs_pkg::crc_byte(crc_out_r, hb);
        hcnt_nxt    = hcnt_r + 3'd1;
        hdr_done    = (op_r == mrs_pkg::OP_RREG || op_r == mrs_pkg::OP_RCOIL) ?
                      (hcnt_r == 3'd2) : (hcnt_r == 3'd5);
        if (hdr_done) begin
          hcnt_nxt = 3'd0;
          case (op_r)
            mrs_pkg::OP_RREG:  state_nxt = mrs_pkg::ST_RREG;
            mrs_pkg::OP_RCOIL: state_nxt = mrs_pkg::ST_RCOIL;
            default:           state_nxt = mrs_pkg::ST_CRC;
          endcase
        end
      end

      // Read registers: fetch a word, send high then low byte.
      mrs_pkg::ST_RREG: begin
        st_raddr = reg_end[AW-1:0];
        st_raddr = pos17[AW-1:0];
        case (ph_r)
          2'd0: begin
            ph_nxt = 2'd1;
          end
          2'd1: begin
            w           = rng_r ? st_rdata : 16'h0000;
            word_nxt    = w;
            strobe_nxt  = 1'b1;
            tx_nxt      = w[15:8];
            crc_out_nxt = mrs_pkg::crc_byte(crc_out_r, w[15:8]);
            ph_nxt      = 2'd2;
          end
          default: begin
            strobe_nxt  = 1'b1;
            tx_nxt      = word_r[7:0];
            crc_out_nxt = mrs_pkg::crc_byte(crc_out_r, word_r[7:0]);
            ph_nxt      = 2'd0;
            k_nxt       = k_r + 16'd1;
            if (k_last) begin
              state_nxt = mrs_pkg::ST_CRC;
            end
          end
        endcase
      end

      // Read coils: fetch the word of each coil and pack the bits LSB first.
      mrs_pkg::ST_RCOIL: begin
        st_raddr = coil_word[AW-1:0];
        if (ph_r == 2'd0) begin
          bitsel_nxt = pos17[3:0];
          ph_nxt     = 2'd1;
        end else begin
          bit_v  = rng_r & st_rdata[bitsel_r];
          accn   = acc_r | (8'(bit_v) << k_r[2:0]);
          ph_nxt = 2'd0;
          k_nxt  = k_r + 16'd1;
          if (k_r[2:0] == 3'd7 || k_last) begin
            strobe_nxt  = 1'b1;
            tx_nxt      = accn;
            crc_out_nxt = mrs_pkg::crc_byte(crc_out_r, accn);
            acc_nxt     = 8'h00;
          end else begin
            acc_nxt = accn;
          end
          if (k_last) begin
            state_nxt = mrs_pkg::ST_CRC;
          end
        end
      end

      // Write registers: two buffer bytes per store word.
      mrs_pkg::ST_WREG: begin
        case (ph_r)
          2'd0: begin
            fb_raddr = buf_a0[FAW-1:0];
            ph_nxt   = 2'd1;
          end
          2'd1: begin
            word_nxt = {fb_rdata, 8'h00};
            fb_raddr = buf_a1[FAW-1:0];
            ph_nxt   = 2'd2;
          end
          default: begin
            st_we    = 1'b1;
            st_waddr = pos17[AW-1:0];
            st_wdata = {word_r[15:8], fb_rdata};
            ph_nxt   = 2'd0;
            k_nxt    = k_r + 16'd1;
            if (k_last) begin
              k_nxt     = 16'd0;
              state_nxt = mrs_pkg::ST_HDR;
            end
          end
        endcase
      end

      // Write coils: read, patch one bit, write back.
      mrs_pkg::ST_WCOIL: begin
        st_raddr = coil_word[AW-1:0];
        fb_raddr = buf_ac[FAW-1:0];
        if (ph_r == 2'd0) begin
          waddr_nxt  = coil_word[AW-1:0];
          bitsel_nxt = pos17[3:0];
          ph_nxt     = 2'd1;
        end else begin
          bit_v    = fb_rdata[k_r[2:0]];
          w        = st_rdata;
          w[bitsel_r] = bit_v;
          st_we    = 1'b1;
          st_waddr = waddr_r;
          st_wdata = w;
          ph_nxt   = 2'd0;
          k_nxt    = k_r + 16'd1;
          if (k_last) begin
            state_nxt = mrs_pkg::ST_HDR;
          end
        end
      end

      // Trailing CRC, low byte first.
      mrs_pkg::ST_CRC: begin
        strobe_nxt = 1'b1;
        if (hcnt_r == 3'd0) begin
          tx_nxt   = crc_out_r[7:0];
          hcnt_nxt = 3'd1;
        end else begin
          tx_nxt    = crc_out_r[15:8];
          last_nxt  = 1'b1;
          state_nxt = mrs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/modbus_rtu_slave_register_file.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU slave register file
// Modbus RTU slave (functions 01, 03, 0F, 10) over a 16-bit register store.
// ----------------------------------------------------------------------------
// A received byte or a local write leaves busy low and the next word may
// follow at once; a local read holds busy while the store is read. An
// end-of-frame word for a frame of four or more bytes that did not
// overflow holds busy while the frame buffer is streamed, one byte a
// cycle, then the check state and, for an accepted request, the reply:
// one cycle per header byte, the register or coil reads or writes, and
// two CRC bytes. The store and the frame buffer each have one read port.
// After reset busy stays high while the store is cleared. Results
// appear for one cycle on out_strobe and cannot be stalled.
module modbus_rtu_slave_register_file #(
  parameter int REG_DEPTH     = mrs_pkg::REG_DEPTH_DEF,
  parameter int FRAME_BYTES   = mrs_pkg::FRAME_BYTES_DEF,
  parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEF,
  parameter int MAX_COILS     = mrs_pkg::MAX_COILS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_local_index,
  input  logic [15:0] in_local_data,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [15:0] out_read_word,
  output logic [1:0]  out_drop_cause,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW  = $clog2(REG_DEPTH);
  localparam int FAW = $clog2(FRAME_BYTES);

  logic [7:0]     slave_addr_r;
  logic [7:0]     coil_base_r;
  logic           st_we;
  logic [AW-1:0]  st_waddr, st_raddr;
  logic [15:0]    st_wdata, st_rdata;
  logic           fb_we;
  logic [FAW-1:0] fb_waddr, fb_raddr;
  logic [7:0]     fb_wdata, fb_rdata;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
      coil_base_r  <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mrs_pkg::CFG_SLAVE_ADDR) begin
        slave_addr_r <= cfg_data;
      end else begin
        coil_base_r <= cfg_data;
      end
    end
  end

  // Register store.
  mrs_ram #(
    .WIDTH(16),
    .DEPTH(REG_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  // Frame buffer.
  mrs_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_fbuf (
    .clk  (clk),
    .we   (fb_we),
    .waddr(fb_waddr),
    .wdata(fb_wdata),
    .raddr(fb_raddr),
    .rdata(fb_rdata)
  );

  // Frame sequencer.
  mrs_ctrl #(
    .REG_DEPTH    (REG_DEPTH),
    .FRAME_BYTES  (FRAME_BYTES),
    .MAX_READ_REGS(MAX_READ_REGS),
    .MAX_COILS    (MAX_COILS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .opcode        (in_opcode),
    .rx_byte       (in_rx_byte),
    .local_index   (in_local_index),
    .local_data    (in_local_data),
    .slave_addr    (slave_addr_r),
    .coil_base     (coil_base_r),
    .st_we         (st_we),
    .st_waddr      (st_waddr),
    .st_wdata      (st_wdata),
    .st_raddr      (st_raddr),
    .st_rdata      (st_rdata),
    .fb_we         (fb_we),
    .fb_waddr      (fb_waddr),
    .fb_wdata      (fb_wdata),
    .fb_raddr      (fb_raddr),
    .fb_rdata      (fb_rdata),
    .out_strobe    (out_strobe),
    .out_kind      (out_kind),
    .out_tx_byte   (out_tx_byte),
    .out_read_word (out_read_word),
    .out_drop_cause(out_drop_cause),
    .out_last      (out_last)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU slave register file testbench
// Drives received bytes, frame ends and local store accesses through the
// command port. A built-in model of the slave keeps its own store, frame
// buffer and settings, predicts every reply byte, read word, write
// acknowledge and drop, and checks the results in order. The slave address
// and coil base are changed between idle phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_GOAL   = 360;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [15:0] word;
    logic [1:0]  cause;
    logic        last;
  } result_t;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  rx;
    logic [7:0]  idx;
    logic [15:0] data;
    bit          typed;
    result_t     want;
  } stim_row_t;

  typedef enum int {
    FR_RREG, FR_RCOIL, FR_WREG, FR_WCOIL, FR_BADCRC,
    FR_ADDR, FR_FUNC, FR_OVF, FR_SHORT, FR_BADLEN
  } frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [7:0]  in_rx_byte;
  logic [7:0]  in_local_index;
  logic [15:0] in_local_data;
  logic        out_strobe;
  logic [1:0]  out_kind;
  logic [7:0]  out_tx_byte;
  logic [15:0] out_read_word;
  logic [1:0]  out_drop_cause;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  modbus_rtu_slave_register_file uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_rx_byte(in_rx_byte),
    .in_local_index(in_local_index), .in_local_data(in_local_data),
    .out_strobe(out_strobe), .out_kind(out_kind), .out_tx_byte(out_tx_byte),
    .out_read_word(out_read_word), .out_drop_cause(out_drop_cause),
    .out_last(out_last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model state of the slave.
  logic [15:0] mdl_store [0:255];
  logic [7:0]  mdl_frame [0:63];
  int          mdl_flen;
  bit          mdl_fovf;
  logic [7:0]  mdl_addr;
  logic [7:0]  mdl_coil_base;

  result_t     pending_results [$];
  result_t     step_results [$];
  int          errors;
  int          words_sent;
  int          frames_sent;
  int          replies_seen;
  int          drops_seen;
  int          cfg_writes;
  longint      cycles = 0;

  // Clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("modbus_rtu_slave_register_file regression: fail");
      $finish;
    end
  end

  function automatic logic [15:0] frame_crc(input logic [7:0] b[$]);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (b[i]) begin
      c = c ^ {8'h00, b[i]};
      for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void add_result(input logic [1:0] kind, input logic [7:0] tx,
                                     input logic [15:0] word, input logic [1:0] cause,
                                     input logic last);
    result_t r;
    r.kind = kind; r.tx = tx; r.word = word; r.cause = cause; r.last = last;
    step_results = {step_results, r};
  endfunction

  // Shorthand for a dropped frame.
  function automatic void add_drop(input logic [1:0] cause);
    add_result(mrs_pkg::KIND_DROP, 8'h0, 16'h0, cause, 1'b1);
  endfunction

  // Reply bytes followed by their CRC, low byte first.
  function automatic void add_reply(input logic [7:0] r[$]);
    logic [15:0] c;
    c = frame_crc(r);
    r = {r, c[7:0], c[15:8]};
    foreach (r[i])
      add_result(mrs_pkg::KIND_BYTE, r[i], 16'h0, 2'd0, i == r.size() - 1);
  endfunction

  // Checks and serves a completed frame.
  function automatic void serve_frame();
    logic [7:0]  body_bytes [$];
    logic [7:0]  r [$];
    logic [7:0]  fn;
    logic [15:0] c, w;
    int          len, body, st, cnt, nb, pos, wi, bitv;
    len = mdl_flen;
    if (mdl_fovf) begin
      add_drop(mrs_pkg::CAUSE_LEN);
      return;
    end
    if (len < 4) begin
      add_drop(mrs_pkg::CAUSE_CRC);
      return;
    end
    for (int i = 0; i < len - 2; i++) body_bytes = {body_bytes, mdl_frame[i]};
    c = frame_crc(body_bytes);
    if (c[7:0] != mdl_frame[len-2] || c[15:8] != mdl_frame[len-1]) begin
      add_drop(mrs_pkg::CAUSE_CRC);
      return;
    end
    if (mdl_frame[0] != mdl_addr) begin
      add_drop(mrs_pkg::CAUSE_ADDR);
      return;
    end
    fn = mdl_frame[1];
    if (fn != mrs_pkg::FN_READ_REGS && fn != mrs_pkg::FN_WRITE_REGS &&
        fn != mrs_pkg::FN_READ_COILS && fn != mrs_pkg::FN_WRITE_COILS) begin
      add_drop(mrs_pkg::CAUSE_FUNC);
      return;
    end
    body = len - 2;
    if (body < 6) begin
      add_drop(mrs_pkg::CAUSE_LEN);
      return;
    end
    st  = {mdl_frame[2], mdl_frame[3]};
    cnt = {mdl_frame[4], mdl_frame[5]};
    r = {mdl_frame[0], mdl_frame[1]};
    if (fn == mrs_pkg::FN_READ_REGS) begin
      if (body != 6 || cnt < 1 || cnt > mrs_pkg::MAX_READ_REGS_DEF) begin
        add_drop(mrs_pkg::CAUSE_LEN);
        return;
      end
      r = {r, 8'(2 * cnt)};
      for (int i = 0; i < cnt; i++) begin
        w = (st + cnt <= 256) ? mdl_store[st + i] : 16'h0;
        r = {r, w[15:8], w[7:0]};
      end
      add_reply(r);
      return;
    end
    if (fn == mrs_pkg::FN_READ_COILS) begin
      if (body != 6 || cnt < 1 || cnt > mrs_pkg::MAX_COILS_DEF) begin
        add_drop(mrs_pkg::CAUSE_LEN);
        return;
      end
      nb = (cnt + 7) / 8;
      r = {r, 8'(nb)};
      for (int i = 0; i < nb; i++) r = {r, 8'h0};
      if (mdl_coil_base + (st + cnt - 1) / 16 < 256) begin
        for (int k = 0; k < cnt; k++) begin
          pos = st + k;
          w = mdl_store[mdl_coil_base + pos / 16];
          r[3 + k / 8][k % 8] = w[pos % 16];
        end
      end
      add_reply(r);
      return;
    end
    // Write requests carry a byte count and data ahead of the CRC.
    if (body < 7) begin
      add_drop(mrs_pkg::CAUSE_LEN);
      return;
    end
    nb = mdl_frame[6];
    if (fn == mrs_pkg::FN_WRITE_REGS) begin
      if (cnt < 1 || cnt > mrs_pkg::MAX_READ_REGS_DEF || nb != 2 * cnt ||
          body != 7 + nb) begin
        add_drop(mrs_pkg::CAUSE_LEN);
        return;
      end
      if (st + cnt <= 256)
        for (int i = 0; i < cnt; i++)
          mdl_store[st + i] = {mdl_frame[7 + 2 * i], mdl_frame[8 + 2 * i]};
    end else begin
      if (cnt < 1 || cnt > mrs_pkg::MAX_COILS_DEF || nb != (cnt + 7) / 8 ||
          body != 7 + nb) begin
        add_drop(mrs_pkg::CAUSE_LEN);
        return;
      end
      if (mdl_coil_base + (st + cnt - 1) / 16 < 256) begin
        for (int k = 0; k < cnt; k++) begin
          pos  = st + k;
          wi   = mdl_coil_base + pos / 16;
          bitv = mdl_frame[7 + k / 8][k % 8];
          mdl_store[wi][pos % 16] = bitv[0];
        end
      end
    end
    for (int i = 2; i < 6; i++) r = {r, mdl_frame[i]};
    add_reply(r);
  endfunction

  // Works out the results of one accepted word.
  function automatic void model_step(input logic [1:0] op, input logic [7:0] rx,
                                     input logic [7:0] idx, input logic [15:0] data);
    step_results.delete();
    case (op)
      mrs_pkg::OPC_RX_BYTE: begin
        if (mdl_flen < mrs_pkg::FRAME_BYTES_DEF) begin
          mdl_frame[mdl_flen] = rx;
          mdl_flen++;
        end else begin
          mdl_fovf = 1'b1;
        end
      end
      mrs_pkg::OPC_END_FRAME: begin
        serve_frame();
        mdl_flen = 0;
        mdl_fovf = 1'b0;
      end
      mrs_pkg::OPC_LOCAL_RD: begin
        add_result(mrs_pkg::KIND_READ, 8'h0, mdl_store[idx], 2'd0, 1'b1);
      end
      default: begin
        mdl_store[idx] = data;
        add_result(mrs_pkg::KIND_WDONE, 8'h0, 16'h0, 2'd0, 1'b1);
      end
    endcase
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      result_t got, want;
      got = {out_kind, out_tx_byte, out_read_word, out_drop_cause, out_last};
      if (got.kind == mrs_pkg::KIND_DROP) drops_seen++;
      if (got.kind == mrs_pkg::KIND_BYTE && got.last) replies_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected kind %0d tx %h word %h cause %0d last %b,",
                     want.kind, want.tx, want.word, want.cause, want.last);
            $display("          got kind %0d tx %h word %h cause %0d last %b",
                     got.kind, got.tx, got.word, got.cause, got.last);
          end
        end
      end
    end
  end

  // Sends one word after a random gap and records what it should produce.
  task automatic send_word(input logic [1:0] op, input logic [7:0] rx,
                           input logic [7:0] idx, input logic [15:0] data,
                           input bit typed = 0, input result_t want = '0);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_rx_byte     <= rx;
    in_local_index <= idx;
    in_local_data  <= data;
    do @(posedge clk); while (busy);
    model_step(op, rx, idx, data);
    if (typed) begin
      step_results.delete();
      step_results = {step_results, want};
    end
    foreach (step_results[i]) pending_results = {pending_results, step_results[i]};
    words_sent++;
  endtask

  // Holds off until every expected result is in and the block has settled.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mrs_pkg::CFG_SLAVE_ADDR) mdl_addr = val;
    else mdl_coil_base = val;
    cfg_writes++;
  endtask

  // Builds a request frame of the given shape, sends it byte by byte, then ends the frame.
  task automatic send_frame(input frame_kind_t k);
    logic [7:0]  f [$];
    logic [7:0]  fn;
    logic [15:0] c;
    int          cnt, st, nb, n, sel;
    bit          coils, wr, bad_cnt;
    frames_sent++;
    if (k == FR_OVF || k == FR_SHORT) begin
      n = (k == FR_OVF) ? $urandom_range(65, 70) : $urandom_range(0, 3);
      repeat (n) f = {f, 8'($urandom)};
    end else begin
      case (k)
        FR_RREG:  fn = mrs_pkg::FN_READ_REGS;
        FR_RCOIL: fn = mrs_pkg::FN_READ_COILS;
        FR_WREG:  fn = mrs_pkg::FN_WRITE_REGS;
        FR_WCOIL: fn = mrs_pkg::FN_WRITE_COILS;
        FR_FUNC: begin
          do fn = 8'($urandom);
          while (fn == mrs_pkg::FN_READ_REGS || fn == mrs_pkg::FN_READ_COILS ||
                 fn == mrs_pkg::FN_WRITE_REGS || fn == mrs_pkg::FN_WRITE_COILS);
        end
        default: begin
          sel = $urandom_range(0, 3);
          fn = (sel == 0) ? mrs_pkg::FN_READ_REGS :
               (sel == 1) ? mrs_pkg::FN_READ_COILS :
               (sel == 2) ? mrs_pkg::FN_WRITE_REGS : mrs_pkg::FN_WRITE_COILS;
        end
      endcase
      coils   = (fn == mrs_pkg::FN_READ_COILS || fn == mrs_pkg::FN_WRITE_COILS);
      wr      = (fn == mrs_pkg::FN_WRITE_REGS || fn == mrs_pkg::FN_WRITE_COILS);
      bad_cnt = ($urandom_range(0, 9) == 0);
      if (bad_cnt)
        cnt = $urandom_range(0, 1) ? 0 :
              (coils ? mrs_pkg::MAX_COILS_DEF + 1 : mrs_pkg::MAX_READ_REGS_DEF + 1);
      else
        cnt = coils ? $urandom_range(1, mrs_pkg::MAX_COILS_DEF) :
                      $urandom_range(1, mrs_pkg::MAX_READ_REGS_DEF);
      // Mostly low addresses so writes and reads meet; some near and past the end.
      case ($urandom_range(0, 5))
        0:       st = $urandom_range(0, 65535);
        1:       st = coils ? $urandom_range(3900, 4200) : $urandom_range(235, 260);
        default: st = coils ? $urandom_range(0, 600) : $urandom_range(0, 40);
      endcase
      f = {(k == FR_ADDR) ? 8'(mdl_addr + $urandom_range(1, 255)) : mdl_addr, fn,
           8'(st >> 8), 8'(st), 8'(cnt >> 8), 8'(cnt)};
      if (wr) begin
        nb = coils ? (cnt + 7) / 8 : 2 * cnt;
        if ($urandom_range(0, 11) == 0) nb = nb + 1;
        f = {f, 8'(nb)};
        repeat (nb) f = {f, 8'($urandom)};
      end
      if (k == FR_BADLEN) f = {f, 8'($urandom)};
      c = frame_crc(f);
      f = {f, c[7:0], c[15:8]};
      if (k == FR_BADCRC) begin
        n = $urandom_range(0, f.size() - 1);
        f[n][$urandom_range(0, 7)] ^= 1'b1;
      end
    end
    foreach (f[i]) send_word(mrs_pkg::OPC_RX_BYTE, f[i], 8'($urandom), 16'($urandom));
    send_word(mrs_pkg::OPC_END_FRAME, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic random_traffic(input int goal);
    int pick;
    while (words_sent < goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 4)
        send_word(mrs_pkg::OPC_LOCAL_RD, 8'($urandom), 8'($urandom), 16'($urandom));
      else if (pick < 6)
        send_word(mrs_pkg::OPC_LOCAL_WR, 8'($urandom), 8'($urandom), 16'($urandom));
      else if (pick < 9) send_frame(FR_RREG);
      else if (pick < 11) send_frame(FR_WREG);
      else if (pick < 13) send_frame(FR_RCOIL);
      else if (pick < 15) send_frame(FR_WCOIL);
      else send_frame(frame_kind_t'($urandom_range(FR_BADCRC, FR_BADLEN)));
    end
  endtask

  // Directed words: local access at the index extremes and short frames.
  stim_row_t directed [] = '{
    '{mrs_pkg::OPC_LOCAL_RD,  8'h00, 8'h00, 16'h0000, 1,
      '{mrs_pkg::KIND_READ,  8'h0, 16'h0000, 2'd0, 1'b1}},
    '{mrs_pkg::OPC_LOCAL_RD,  8'h00, 8'hFF, 16'hFFFF, 1,
      '{mrs_pkg::KIND_READ,  8'h0, 16'h0000, 2'd0, 1'b1}},
    '{mrs_pkg::OPC_LOCAL_WR,  8'hFF, 8'hFF, 16'hFFFF, 1,
      '{mrs_pkg::KIND_WDONE, 8'h0, 16'h0000, 2'd0, 1'b1}},
    '{mrs_pkg::OPC_LOCAL_RD,  8'h00, 8'hFF, 16'h0000, 1,
      '{mrs_pkg::KIND_READ,  8'h0, 16'hFFFF, 2'd0, 1'b1}},
    '{mrs_pkg::OPC_LOCAL_WR,  8'h00, 8'h00, 16'h8001, 1,
      '{mrs_pkg::KIND_WDONE, 8'h0, 16'h0000, 2'd0, 1'b1}},
    '{mrs_pkg::OPC_LOCAL_RD,  8'hFF, 8'h00, 16'h0000, 1,
      '{mrs_pkg::KIND_READ,  8'h0, 16'h8001, 2'd0, 1'b1}},
    '{mrs_pkg::OPC_LOCAL_WR,  8'h00, 8'h01, 16'h5AA5, 0, '0},
    '{mrs_pkg::OPC_LOCAL_RD,  8'h00, 8'h01, 16'h0000, 0, '0},
    '{mrs_pkg::OPC_END_FRAME, 8'h00, 8'h00, 16'h0000, 1,
      '{mrs_pkg::KIND_DROP,  8'h0, 16'h0000, mrs_pkg::CAUSE_CRC, 1'b1}},
    '{mrs_pkg::OPC_RX_BYTE,   8'h00, 8'h00, 16'h0000, 0, '0},
    '{mrs_pkg::OPC_RX_BYTE,   8'hFF, 8'hFF, 16'hFFFF, 0, '0},
    '{mrs_pkg::OPC_RX_BYTE,   8'h55, 8'hAA, 16'h1234, 0, '0},
    '{mrs_pkg::OPC_END_FRAME, 8'hFF, 8'hFF, 16'hFFFF, 1,
      '{mrs_pkg::KIND_DROP,  8'h0, 16'h0000, mrs_pkg::CAUSE_CRC, 1'b1}}
  };

  initial begin
    int left;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = mrs_pkg::OPC_RX_BYTE;
    in_rx_byte = 8'h0;
    in_local_index = 8'h0;
    in_local_data = 16'h0;
    cfg_valid = 1'b0;
    cfg_index = mrs_pkg::CFG_SLAVE_ADDR;
    cfg_data = 8'h0;
    errors = 0;
    words_sent = 0;
    frames_sent = 0;
    replies_seen = 0;
    drops_seen = 0;
    cfg_writes = 0;
    foreach (mdl_store[i]) mdl_store[i] = 16'h0;
    mdl_flen = 0;
    mdl_fovf = 1'b0;
    mdl_addr = 8'd1;
    mdl_coil_base = 8'd0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_word(directed[i].op, directed[i].rx, directed[i].idx, directed[i].data,
                directed[i].typed, directed[i].want);
    for (int k = FR_RREG; k <= FR_BADLEN; k++) send_frame(frame_kind_t'(k));

    // Random traffic under several address and coil base settings, filling
    // up the remaining word budget.
    left = (words_sent < ITEM_GOAL) ? ITEM_GOAL - words_sent : 0;
    write_cfg(mrs_pkg::CFG_SLAVE_ADDR, 8'd247);
    write_cfg(mrs_pkg::CFG_COIL_BASE, 8'd255);
    random_traffic(words_sent + left / 4);
    write_cfg(mrs_pkg::CFG_SLAVE_ADDR, 8'd1);
    write_cfg(mrs_pkg::CFG_COIL_BASE, 8'd0);
    random_traffic(words_sent + left / 4);
    drain();
    random_traffic(words_sent + left / 8);
    write_cfg(mrs_pkg::CFG_SLAVE_ADDR, 8'($urandom_range(1, 247)));
    write_cfg(mrs_pkg::CFG_COIL_BASE, 8'($urandom_range(0, 255)));
    random_traffic(ITEM_GOAL);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d words in %0d frames plus local access, %0d replies, %0d drops",
             words_sent, frames_sent, replies_seen, drops_seen);
    $display("%0d configuration writes, %0d errors", cfg_writes, errors);
    if (errors == 0) begin
      $display("modbus_rtu_slave_register_file regression: pass");
    end else begin
      $display("modbus_rtu_slave_register_file regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mrs_pkg.sv
design/mrs_ram.sv
design/mrs_ctrl.sv
design/modbus_rtu_slave_register_file.sv
dv/tb_top.sv
